/* rtl/rbr_pkg.sv */
package rbr_pkg;

    // Angles are in 1/64 degree.
    localparam logic [14:0] FULL_TURN          = 15'd23040;
    localparam logic [14:0] THREE_QUARTER_TURN = 15'd17280;
    localparam logic [14:0] HALF_TURN          = 15'd11520;
    localparam logic [14:0] QUARTER_TURN       = 15'd5760;

    localparam logic [12:0] RANGE_MAX = 13'd8191;

    localparam int unsigned CORDIC_STAGES_DEF = 16;
    localparam int unsigned CORDIC_STAGES_MAX = 24;

    // The squared distance fits in 25 bits, so the root takes 13 steps of two bits.
    localparam int unsigned ROOT_STEPS = 13;
    localparam int unsigned RAD_W      = 26;
    localparam int unsigned CORD_W     = 40;
    localparam int unsigned Z_W        = 32;
    localparam int unsigned POS_SHIFT  = 24;

    localparam int unsigned IN_TDATA_W  = 64;
    localparam int unsigned OUT_TDATA_W = 32;

    // atan(2^-i) in degrees, times 64 * 65536, rounded to nearest.
    localparam logic signed [Z_W-1:0] ATAN_TAB [0:CORDIC_STAGES_MAX-1] = '{
        32'sd188743680, 32'sd111421900, 32'sd58872272, 32'sd29884485,
        32'sd15000234,  32'sd7507429,   32'sd3754631,  32'sd1877430,
        32'sd938729,    32'sd469366,    32'sd234683,   32'sd117342,
        32'sd58671,     32'sd29335,     32'sd14668,    32'sd7334,
        32'sd3667,      32'sd1833,      32'sd917,      32'sd458,
        32'sd229,       32'sd115,       32'sd57,       32'sd29
    };

    typedef struct packed {
        logic signed [12:0] dx;
        logic signed [12:0] dy;
        logic [14:0]        hd;
    } t_delta;

    typedef struct packed {
        logic signed [CORD_W-1:0] x;
        logic signed [CORD_W-1:0] y;
        logic signed [Z_W-1:0]    z;
        logic [RAD_W-1:0]         rad;
        logic [RAD_W-1:0]         root;
        logic [14:0]              hd;
        logic                     dx_neg;
        logic                     dy_neg;
        logic                     dx_zero;
        logic                     dy_zero;
    } t_iter;

    typedef struct packed {
        logic [14:0] dir;
        logic [14:0] hd;
        logic [12:0] range;
    } t_fin;

    typedef struct packed {
        logic signed [14:0] turn;
        logic               side;
        logic [12:0]        range;
    } t_res;

endpackage

/* rtl/relative_bearing_range.sv */
// Relative bearing and range of a target seen from a robot. Each request carries the robot
// position, the robot heading and the target position; the block returns one result with
// the shortest signed turn toward the target (1/64 degree, negative is a left turn), a side
// flag (1 = left) and the Euclidean distance, saturated to 13 bits. The target direction is
// a four-quadrant arctangent built from CORDIC_STAGES vectoring stages; points on an axis
// give an exact multiple of 90 degrees and coincident points give direction 0 and range 0.
// The datapath is a pipeline whose stages each do at most one CORDIC iteration and one
// two-bit square root step, so a new request is taken every clock cycle while the output
// is not stalled. Results pass stages 1 and 2, the iteration stages and both final stages.
// A two-entry arrangement of input skid register and output register lets the block take
// one more request while the front result waits on the output.
module relative_bearing_range #(
    parameter int unsigned CORDIC_STAGES = rbr_pkg::CORDIC_STAGES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // From bit 0: robot_x[11:0], robot_y[11:0], robot_heading[14:0], target_x[11:0],
    // target_y[11:0], one zero pad bit.
    input  logic [rbr_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // From bit 0: turn_angle[14:0] (signed), target_side, target_range[12:0], three zero
    // pad bits.
    output logic [rbr_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata
);

    // Number of iteration stages: the longer of the arctangent and the square root.
    localparam int unsigned PIPE_LEN = (CORDIC_STAGES > rbr_pkg::ROOT_STEPS) ?
                                       CORDIC_STAGES : rbr_pkg::ROOT_STEPS;

    // Width of the squared distance and of the root being built.
    localparam int unsigned RAD_W = rbr_pkg::RAD_W;

    // The whole pipeline moves together whenever the output register is free or drained.
    logic w_adv;
    logic w_accept;

    // Input skid register, filled only when a request arrives during a stall.
    logic                            r_skid_vld;
    logic [rbr_pkg::IN_TDATA_W-1:0]  r_skid_data;
    logic                            w_src_vld;
    logic [rbr_pkg::IN_TDATA_W-1:0]  w_src_data;

    logic                   r_v1;
    rbr_pkg::t_delta        r_s1;
    rbr_pkg::t_delta        n_s1;

    logic [PIPE_LEN:0]      r_vit;
    rbr_pkg::t_iter         r_it [0:PIPE_LEN];
    rbr_pkg::t_iter         n_it [0:PIPE_LEN];

    logic                   r_vf1;
    rbr_pkg::t_fin          r_f1;
    rbr_pkg::t_fin          n_f1;

    logic                   r_vout;
    rbr_pkg::t_res          r_out;
    rbr_pkg::t_res          n_out;

    assign w_adv           = !r_vout || i_m_axis_tready;
    assign o_s_axis_tready = !r_skid_vld;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_src_vld       = r_skid_vld || i_s_axis_tvalid;
    assign w_src_data      = r_skid_vld ? r_skid_data : i_s_axis_tdata;

    // Stage 1: coordinate differences and heading folded into one turn.
    always_comb begin
        logic [11:0] rx, ry, tx, ty;
        logic [14:0] hd;
        rx = w_src_data[11:0];
        ry = w_src_data[23:12];
        hd = w_src_data[38:24];
        tx = w_src_data[50:39];
        ty = w_src_data[62:51];
        n_s1.dx = $signed({1'b0, tx}) - $signed({1'b0, rx});
        n_s1.dy = $signed({1'b0, ty}) - $signed({1'b0, ry});
        n_s1.hd = (hd > rbr_pkg::FULL_TURN) ? hd - rbr_pkg::FULL_TURN : hd;
    end

    // Stage 2: magnitudes, quadrant flags, squared distance and the CORDIC start vector.
    always_comb begin
        logic [11:0]              ax, ay;
        logic signed [RAD_W-1:0]  dx2, dy2;
        ax  = r_s1.dx[12] ? 12'(-r_s1.dx) : r_s1.dx[11:0];
        ay  = r_s1.dy[12] ? 12'(-r_s1.dy) : r_s1.dy[11:0];
        dx2 = r_s1.dx * r_s1.dx;
        dy2 = r_s1.dy * r_s1.dy;
        n_it[0].x       = $signed({4'b0, ax, {rbr_pkg::POS_SHIFT{1'b0}}});
        n_it[0].y       = $signed({4'b0, ay, {rbr_pkg::POS_SHIFT{1'b0}}});
        n_it[0].z       = '0;
        n_it[0].rad     = RAD_W'(dx2) + RAD_W'(dy2);
        n_it[0].root    = '0;
        n_it[0].hd      = r_s1.hd;
        n_it[0].dx_neg  = r_s1.dx[12];
        n_it[0].dy_neg  = r_s1.dy[12];
        n_it[0].dx_zero = (r_s1.dx == '0);
        n_it[0].dy_zero = (r_s1.dy == '0);
    end

    // Iteration stages: at most one CORDIC rotation and one square root step each.
    for (genvar j = 0; j < PIPE_LEN; j++) begin : g_iter
        localparam bit          DO_CORD = (j < CORDIC_STAGES);
        localparam bit          DO_ROOT = (j < rbr_pkg::ROOT_STEPS);
        localparam int unsigned RSH     = DO_ROOT ? (2 * (rbr_pkg::ROOT_STEPS - 1 - j)) : 0;
        localparam int unsigned TIDX    = DO_CORD ? j : 0;

        always_comb begin
            logic signed [rbr_pkg::CORD_W-1:0] xs, ys;
            logic [RAD_W-1:0]                  rbit, trial;
            xs    = r_it[j].x >>> j;
            ys    = r_it[j].y >>> j;
            rbit  = RAD_W'(1) << RSH;
            trial = r_it[j].root + rbit;
            n_it[j+1] = r_it[j];
            if (DO_CORD) begin
                if (r_it[j].y > 0) begin
                    n_it[j+1].x = r_it[j].x + ys;
                    n_it[j+1].y = r_it[j].y - xs;
                    n_it[j+1].z = r_it[j].z + rbr_pkg::ATAN_TAB[TIDX];
                end else if (r_it[j].y < 0) begin
                    n_it[j+1].x = r_it[j].x - ys;
                    n_it[j+1].y = r_it[j].y + xs;
                    n_it[j+1].z = r_it[j].z - rbr_pkg::ATAN_TAB[TIDX];
                end
            end
            if (DO_ROOT) begin
                if (r_it[j].rad >= trial) begin
                    n_it[j+1].rad  = r_it[j].rad - trial;
                    n_it[j+1].root = (r_it[j].root >> 1) + rbit;
                end else begin
                    n_it[j+1].root = r_it[j].root >> 1;
                end
            end
        end
    end

    // Final stage 1: quadrant angle to full direction, root rounding and saturation.
    always_comb begin
        logic signed [rbr_pkg::Z_W-1:0] zc, zr;
        logic [15:0]                    q;
        logic [14:0]                    a;
        logic [14:0]                    d;
        logic [RAD_W-1:0]               rr;
        zc = (r_it[PIPE_LEN].z < 0) ? '0 : r_it[PIPE_LEN].z;
        zr = (zc + 32'sd32768) >>> 16;
        q  = zr[15:0];
        a  = (q > 16'(rbr_pkg::QUARTER_TURN)) ? rbr_pkg::QUARTER_TURN : q[14:0];
        priority if (r_it[PIPE_LEN].dx_zero && r_it[PIPE_LEN].dy_zero) begin
            d = '0;
        end else if (r_it[PIPE_LEN].dx_zero) begin
            d = r_it[PIPE_LEN].dy_neg ? rbr_pkg::THREE_QUARTER_TURN : rbr_pkg::QUARTER_TURN;
        end else if (r_it[PIPE_LEN].dy_zero) begin
            d = r_it[PIPE_LEN].dx_neg ? rbr_pkg::HALF_TURN : '0;
        end else if (!r_it[PIPE_LEN].dx_neg && !r_it[PIPE_LEN].dy_neg) begin
            d = a;
        end else if (r_it[PIPE_LEN].dx_neg && !r_it[PIPE_LEN].dy_neg) begin
            d = rbr_pkg::HALF_TURN - a;
        end else if (r_it[PIPE_LEN].dx_neg) begin
            d = rbr_pkg::HALF_TURN + a;
        end else begin
            d = rbr_pkg::FULL_TURN - a;
        end
        n_f1.dir = (d == rbr_pkg::FULL_TURN) ? '0 : d;
        n_f1.hd  = r_it[PIPE_LEN].hd;
        rr = r_it[PIPE_LEN].root;
        if (r_it[PIPE_LEN].rad > rr) begin
            rr = rr + RAD_W'(1);
        end
        n_f1.range = (rr > RAD_W'(rbr_pkg::RANGE_MAX)) ? rbr_pkg::RANGE_MAX : rr[12:0];
    end

    // Final stage 2: heading minus direction, shorter of the two turns.
    always_comb begin
        logic signed [15:0] diff;
        logic [14:0]        a1, a2, mag;
        logic               left;
        diff = $signed({1'b0, r_f1.hd}) - $signed({1'b0, r_f1.dir});
        a1   = diff[15] ? 15'(-diff) : diff[14:0];
        a2   = rbr_pkg::FULL_TURN - a1;
        if (diff > 0) begin
            left = (a1 > a2);
        end else begin
            left = (a1 <= a2);
        end
        mag = (a1 <= a2) ? a1 : a2;
        n_out.turn  = left ? $signed(-mag) : $signed(mag);
        n_out.side  = left;
        n_out.range = r_f1.range;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
            r_v1       <= 1'b0;
            r_vit      <= '0;
            r_vf1      <= 1'b0;
            r_vout     <= 1'b0;
        end else begin
            if (w_adv) begin
                r_skid_vld <= 1'b0;
                r_v1       <= w_src_vld;
                r_vit      <= {r_vit[PIPE_LEN-1:0], r_v1};
                r_vf1      <= r_vit[PIPE_LEN];
                r_vout     <= r_vf1;
            end else if (w_accept) begin
                r_skid_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_adv && w_accept) begin
            r_skid_data <= i_s_axis_tdata;
        end
        if (w_adv) begin
            r_s1 <= n_s1;
            for (int k = 0; k <= PIPE_LEN; k++) begin
                r_it[k] <= n_it[k];
            end
            r_f1  <= n_f1;
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_vout;
    assign o_m_axis_tdata  = {3'b000, r_out.range, r_out.side, r_out.turn};

endmodule
